// File: rtl/pse_pkg.sv
`default_nettype none
package pse_pkg;

    localparam int NUM_TERMS = 32;
    localparam int IDX_W     = $clog2(NUM_TERMS);

    localparam logic [2:0] OP_ASSIGN = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_EVAL   = 3'd4;
    localparam logic [2:0] OP_INTEG  = 3'd5;
    localparam logic [2:0] OP_DIFF   = 3'd6;
    localparam logic [2:0] OP_ANTI   = 3'd7;

    localparam logic signed [47:0] Q48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] Q48_MIN = 48'sh8000_0000_0000;
    localparam logic signed [31:0] Q32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [2:0]         operation;
        logic [5:0]         exponent;
        logic signed [31:0] coef_value;
        logic signed [31:0] x_point;
        logic signed [31:0] x_upper;
    } t_in;

    typedef struct packed {
        logic signed [47:0] result_value;
        logic               saturated;
        logic [5:0]         poly_degree;
        logic               all_zero;
    } t_out;

    typedef struct packed {
        t_in  req;
        logic in_range;
    } t_cmd;

endpackage
`default_nettype wire

// File: rtl/pse_front.sv
`default_nettype none
module pse_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pse_pkg::t_in  i_req,
    output logic               o_full,
    output logic               o_cmd_vld,
    output pse_pkg::t_cmd      o_cmd,
    input  wire logic          i_cmd_take
);
    import pse_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;
    t_cmd       w_cmd;

    assign o_full    = (r_cnt == 2'd2);
    assign o_cmd_vld = (r_cnt != 2'd0);
    assign o_cmd     = r_mem[r_rp];
    assign w_wr      = i_push && !o_full;
    assign w_rd      = i_cmd_take && o_cmd_vld;

    // classify: exponent against store size
    always_comb begin
        w_cmd.req      = i_req;
        w_cmd.in_range = ({1'b0, i_req.exponent} < 7'(NUM_TERMS));
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

endmodule
`default_nettype wire

// File: rtl/pse_back.sv
`default_nettype none
module pse_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_vld,
    input  wire pse_pkg::t_cmd i_cmd,
    output logic               o_cmd_take,
    output pse_pkg::t_out      o_res,
    output logic               o_empty,
    input  wire logic          i_pop
);
    import pse_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SHORT = 3'd1;
    localparam logic [2:0] ST_LOOP  = 3'd2;
    localparam logic [2:0] ST_TAIL  = 3'd3;
    localparam logic [2:0] ST_FIN1  = 3'd4;
    localparam logic [2:0] ST_FIN2  = 3'd5;

    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(NUM_TERMS - 1);
    localparam logic [IDX_W-1:0] IDX_PRE = IDX_W'(NUM_TERMS - 2);

    // store
    logic [31:0]          mem [NUM_TERMS];
    logic [NUM_TERMS-1:0] r_vld;
    logic [NUM_TERMS-1:0] r_nz;
    logic [31:0]          r_rd_data;
    logic                 r_rd_vld;

    logic [2:0]         r_st;
    t_cmd               r_cmd;
    logic [1:0]         r_ph;
    logic [IDX_W-1:0]   r_idx;
    logic               r_pass;
    logic signed [47:0] r_acc;
    logic signed [47:0] r_hi;
    logic               r_clip;
    logic signed [47:0] r_value;

    logic [63:0]        r_mh;
    logic [63:0]        r_p;
    logic [31:0]        r_ca;
    logic               r_cneg;
    logic signed [31:0] r_craw;
    logic [31:0]        r_q0;
    logic signed [39:0] r_dm;
    logic [IDX_W:0]     r_rem;
    logic signed [47:0] r_mq;
    logic               r_mclip;

    logic [7:0]         r_gany;
    logic [2:0]         r_gidx [8];

    t_out               r_out;
    logic               r_out_vld;

    logic [31:0]        w_recip [NUM_TERMS];

    logic               w_rd_en;
    logic [IDX_W-1:0]   w_rd_addr;
    logic               w_wr_en;
    logic [IDX_W-1:0]   w_wr_addr;
    logic signed [31:0] w_wr_data;
    logic               w_clr_all;

    logic signed [31:0] w_c;
    logic [31:0]        w_ca;
    logic signed [31:0] w_x;
    logic [47:0]        w_ma;
    logic [31:0]        w_mx;
    logic               w_neg;
    logic [63:0]        w_ml;
    logic signed [39:0] w_dm;
    logic [37:0]        w_qk;
    logic signed [47:0] w_mq;
    logic               w_mclip;
    logic [31:0]        w_q;
    logic signed [31:0] w_term;
    logic signed [48:0] w_sum;
    logic signed [47:0] w_acc_new;
    logic               w_sclip;
    logic signed [32:0] w_add;
    logic signed [31:0] w_add_sat;
    logic signed [48:0] w_diff;
    logic [63:0]        w_nz64;
    logic [7:0]         w_gany;
    logic [2:0]         w_gidx [8];
    logic [5:0]         w_deg;
    logic               w_horner;
    logic               w_out_free;
    logic               w_top_nz;

    for (genvar g = 0; g < NUM_TERMS; g++) begin : g_recip
        if (g < 2) begin : g_lo
            assign w_recip[g] = 32'd0;
        end else begin : g_hi
            localparam logic [63:0] RECIP_VAL = 64'h1_0000_0000 / g;
            assign w_recip[g] = RECIP_VAL[31:0];
        end
    end

    assign o_res      = r_out;
    assign o_empty    = !r_out_vld;
    assign o_cmd_take = (r_st == ST_IDLE) && i_cmd_vld;
    assign w_out_free = !r_out_vld || i_pop;
    assign w_top_nz   = r_nz[NUM_TERMS-1];
    assign w_horner   = (r_cmd.req.operation == OP_EVAL) || (r_cmd.req.operation == OP_INTEG);

    // term datapath
    always_comb begin
        w_c  = r_rd_vld ? $signed(r_rd_data) : 32'sd0;
        w_ca = w_c[31] ? 32'(-w_c) : 32'(w_c);
        if (r_cmd.req.operation == OP_INTEG && !r_pass) begin
            w_x = r_cmd.req.x_upper;
        end else begin
            w_x = r_cmd.req.x_point;
        end
        w_ma  = r_acc[47] ? 48'(-r_acc) : 48'(r_acc);
        w_mx  = w_x[31] ? 32'(-w_x) : 32'(w_x);
        w_neg = r_acc[47] ^ w_x[31];
        w_ml  = 64'(w_ma) * 64'(w_mx[15:0]);
        w_dm  = 40'(w_c) * 40'({1'b0, r_idx} + 6'd1);
        w_qk  = 38'(r_q0) * 38'(r_idx);

        w_mclip = 1'b0;
        if (w_neg) begin
            if (r_p > 64'h0000_8000_0000_0000) begin
                w_mq    = Q48_MIN;
                w_mclip = 1'b1;
            end else begin
                w_mq = 48'(-$signed(r_p));
            end
        end else if (r_p > 64'h0000_7FFF_FFFF_FFFF) begin
            w_mq    = Q48_MAX;
            w_mclip = 1'b1;
        end else begin
            w_mq = $signed(r_p[47:0]);
        end

        w_q = r_q0 + 32'(r_rem >= {1'b0, r_idx});
        unique case (r_cmd.req.operation)
            OP_EVAL: begin
                w_term = r_craw;
            end
            OP_DIFF: begin
                if (r_dm > 40'(Q32_MAX)) begin
                    w_term = Q32_MAX;
                end else if (r_dm < 40'(Q32_MIN)) begin
                    w_term = Q32_MIN;
                end else begin
                    w_term = 32'(r_dm);
                end
            end
            default: begin
                // antiderivative term: c[k-1] / k, truncated toward zero
                if (r_idx == '0) begin
                    w_term = 32'sd0;
                end else if (r_idx == IDX_W'(1)) begin
                    w_term = r_craw;
                end else begin
                    w_term = r_cneg ? 32'(-$signed(w_q)) : $signed(w_q);
                end
            end
        endcase

        w_sum   = 49'(r_mq) + 49'(w_term);
        w_sclip = 1'b0;
        if (w_sum > 49'(Q48_MAX)) begin
            w_acc_new = Q48_MAX;
            w_sclip   = 1'b1;
        end else if (w_sum < 49'(Q48_MIN)) begin
            w_acc_new = Q48_MIN;
            w_sclip   = 1'b1;
        end else begin
            w_acc_new = 48'(w_sum);
        end

        w_add = 33'(w_c) + 33'(r_cmd.req.coef_value);
        if (w_add > 33'(Q32_MAX)) begin
            w_add_sat = Q32_MAX;
        end else if (w_add < 33'(Q32_MIN)) begin
            w_add_sat = Q32_MIN;
        end else begin
            w_add_sat = 32'(w_add);
        end

        w_diff = 49'(r_hi) - 49'(r_acc);
    end

    // store port control
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_idx;
        w_wr_en   = 1'b0;
        w_wr_addr = r_idx;
        w_wr_data = w_term;
        w_clr_all = 1'b0;
        unique case (r_st)
            ST_IDLE: begin
                w_rd_addr = i_cmd.req.exponent[IDX_W-1:0];
                w_wr_addr = i_cmd.req.exponent[IDX_W-1:0];
                w_wr_data = i_cmd.req.coef_value;
                if (o_cmd_take) begin
                    w_rd_en = 1'b1;
                    unique case (i_cmd.req.operation)
                        OP_ASSIGN: w_wr_en = i_cmd.in_range;
                        OP_CLEAR:  w_clr_all = 1'b1;
                        OP_ANTI:   w_clr_all = w_top_nz;
                        default: ;
                    endcase
                end
            end
            ST_SHORT: begin
                w_wr_addr = r_cmd.req.exponent[IDX_W-1:0];
                w_wr_data = w_add_sat;
                w_wr_en   = (r_cmd.req.operation == OP_ADD) && r_cmd.in_range;
            end
            ST_LOOP: begin
                if (r_cmd.req.operation == OP_EVAL) begin
                    w_rd_addr = r_idx;
                end else if (r_cmd.req.operation == OP_DIFF) begin
                    w_rd_addr = r_idx + IDX_W'(1);
                end else begin
                    w_rd_addr = r_idx - IDX_W'(1);
                end
                w_rd_en = (r_ph == 2'd0);
                w_wr_en = (r_ph == 2'd3) && !w_horner;
            end
            ST_TAIL: begin
                w_wr_en   = 1'b1;
                w_wr_data = 32'sd0;
                w_wr_addr = (r_cmd.req.operation == OP_DIFF) ? IDX_TOP : '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
            r_rd_vld  <= r_vld[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clr_all) begin
            r_vld <= '0;
            r_nz  <= '0;
        end else if (w_wr_en) begin
            r_vld[w_wr_addr] <= 1'b1;
            r_nz[w_wr_addr]  <= (w_wr_data != 32'sd0);
        end
    end

    // degree search, first level: highest nonzero entry in each group of eight
    always_comb begin
        w_nz64 = 64'(r_nz);
        for (int g = 0; g < 8; g++) begin
            w_gany[g] = |w_nz64[8*g +: 8];
            w_gidx[g] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (w_nz64[8*g + b]) begin
                    w_gidx[g] = 3'(b);
                end
            end
        end
    end

    // degree search, second level
    always_comb begin
        w_deg = 6'd0;
        for (int g = 0; g < 8; g++) begin
            if (r_gany[g]) begin
                w_deg = {3'(g), r_gidx[g]};
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd   <= i_cmd;
            r_acc   <= 48'sd0;
            r_hi    <= 48'sd0;
            r_value <= 48'sd0;
            r_clip  <= 1'b0;
            r_pass  <= 1'b0;
            r_ph    <= 2'd0;
            if (i_cmd.req.operation == OP_DIFF) begin
                r_idx <= '0;
            end else begin
                r_idx <= IDX_TOP;
            end
        end
        if (r_st == ST_SHORT && r_cmd.req.operation == OP_READ && r_cmd.in_range) begin
            r_value <= 48'(w_c);
        end
        if (r_st == ST_LOOP) begin
            r_ph <= r_ph + 2'd1;
            unique case (r_ph)
                2'd0: begin
                    r_mh <= 64'(w_ma) * 64'(w_mx[31:16]);
                end
                2'd1: begin
                    r_p    <= r_mh + (w_ml >> 16);
                    r_ca   <= w_ca;
                    r_cneg <= w_c[31];
                    r_craw <= w_c;
                    r_q0   <= 32'((64'(w_ca) * 64'(w_recip[r_idx])) >> 32);
                    r_dm   <= w_dm;
                end
                2'd2: begin
                    r_rem   <= (IDX_W + 1)'(38'(r_ca) - w_qk);
                    r_mq    <= w_mq;
                    r_mclip <= w_mclip;
                end
                default: begin
                    if (w_horner) begin
                        r_clip <= r_clip | r_mclip | w_sclip;
                        if (r_idx == '0 && r_cmd.req.operation == OP_INTEG && !r_pass) begin
                            r_hi   <= w_acc_new;
                            r_acc  <= 48'sd0;
                            r_pass <= 1'b1;
                            r_idx  <= IDX_TOP;
                        end else begin
                            r_acc <= w_acc_new;
                            r_idx <= r_idx - IDX_W'(1);
                        end
                    end else if (r_cmd.req.operation == OP_DIFF) begin
                        r_idx <= r_idx + IDX_W'(1);
                    end else begin
                        r_idx <= r_idx - IDX_W'(1);
                    end
                end
            endcase
        end
        if (r_st == ST_FIN1) begin
            r_gany <= w_gany;
            r_gidx <= w_gidx;
            if (r_cmd.req.operation == OP_EVAL) begin
                r_value <= r_acc;
            end else if (r_cmd.req.operation == OP_INTEG) begin
                if (w_diff > 49'(Q48_MAX)) begin
                    r_value <= Q48_MAX;
                    r_clip  <= 1'b1;
                end else if (w_diff < 49'(Q48_MIN)) begin
                    r_value <= Q48_MIN;
                    r_clip  <= 1'b1;
                end else begin
                    r_value <= 48'(w_diff);
                end
            end
        end
        if (r_st == ST_FIN2 && w_out_free) begin
            r_out.result_value <= r_value;
            r_out.saturated    <= r_clip;
            r_out.poly_degree  <= w_deg;
            r_out.all_zero     <= ~|r_gany;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            if (r_st == ST_FIN2 && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_pop && r_out_vld) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_st)
                ST_IDLE: begin
                    if (o_cmd_take) begin
                        unique case (i_cmd.req.operation)
                            OP_ADD, OP_READ: r_st <= ST_SHORT;
                            OP_EVAL, OP_DIFF: r_st <= ST_LOOP;
                            OP_INTEG, OP_ANTI: r_st <= w_top_nz ? ST_FIN1 : ST_LOOP;
                            default: r_st <= ST_FIN1;
                        endcase
                    end
                end
                ST_SHORT: begin
                    r_st <= ST_FIN1;
                end
                ST_LOOP: begin
                    if (r_ph == 2'd3) begin
                        priority if (w_horner) begin
                            if (r_idx == '0 && !(r_cmd.req.operation == OP_INTEG && !r_pass)) begin
                                r_st <= ST_FIN1;
                            end
                        end else if (r_cmd.req.operation == OP_DIFF) begin
                            if (r_idx == IDX_PRE) begin
                                r_st <= ST_TAIL;
                            end
                        end else begin
                            if (r_idx == IDX_W'(1)) begin
                                r_st <= ST_TAIL;
                            end
                        end
                    end
                end
                ST_TAIL: begin
                    r_st <= ST_FIN1;
                end
                ST_FIN1: begin
                    r_st <= ST_FIN2;
                end
                ST_FIN2: begin
                    if (w_out_free) begin
                        r_st <= ST_IDLE;
                    end
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/polynomial_store_evaluator_top.sv
// from accept to result valid: assign and clear go straight to the finish states; add
// and read pass a short state first; evaluate walks every term once, integrate twice
// (upper, then lower bound), differentiate and antidifferentiate once; integrate and
// antidifferentiate with a nonzero top term skip the walk; one item in work at a time;
// throughput is set by the term step of the back unit (split multiply, one store read port)
// synchronous active-low reset empties both queues and clears the store
`default_nettype none
module polynomial_store_evaluator_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    input  wire pse_pkg::t_in i_req,
    output logic              full,
    output logic              empty,
    input  wire logic         pop,
    output pse_pkg::t_out     o_res
);
    import pse_pkg::*;

    logic w_cmd_vld;
    t_cmd w_cmd;
    logic w_cmd_take;

    pse_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_req      (i_req),
        .o_full     (full),
        .o_cmd_vld  (w_cmd_vld),
        .o_cmd      (w_cmd),
        .i_cmd_take (w_cmd_take)
    );

    pse_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_vld  (w_cmd_vld),
        .i_cmd      (w_cmd),
        .o_cmd_take (w_cmd_take),
        .o_res      (o_res),
        .o_empty    (empty),
        .i_pop      (pop)
    );

endmodule
`default_nettype wire
